// ===== design/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// shared constants, command/status types and helpers for the 3x3 box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int EW_W         = ADDR_W + 1;
  localparam int ROW_W        = 13;
  localparam int PEND_W       = 12;
  localparam int CFG_W        = 13;
  localparam int FW_W         = 12;
  localparam int FH_W         = 13;
  localparam int PIX_W        = 24;
  localparam int CH_W         = 8;
  localparam int SUM_W        = 12;
  localparam int DVD_W        = 13;
  localparam int RCP_W        = 17;
  localparam int RCP_SH       = 17;
  localparam int PROD_W       = DVD_W + RCP_W;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic take_pix;
    logic take_drain;
    logic mem_rd;
    logic advance;
    logic sum_load;
    logic div_step;
    logic out_load;
    logic out_end;
  } bb3_cmd_t;

  typedef struct packed {
    logic pix_ok;
    logic drain_ok;
    logic hit;
    logic last_pend;
    logic out_free;
  } bb3_stat_t;

  function automatic logic [EW_W-1:0] clamp_width(logic [FW_W-1:0] v);
    int unsigned t;
    t = v;
    if (t == 0) t = 1;
    if (t > MAX_WIDTH) t = MAX_WIDTH;
    return EW_W'(t);
  endfunction

  function automatic logic [FH_W-1:0] clamp_height(logic [FH_W-1:0] v);
    int unsigned t;
    t = v;
    if (t == 0) t = 1;
    if (t > HEIGHT_LIMIT) t = HEIGHT_LIMIT;
    return FH_W'(t);
  endfunction

  function automatic logic [1:0] count3(logic [2:0] m);
    logic [1:0] n;
    n = 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
    return n;
  endfunction

  // ceil(2^17 / (2*n)) for each possible neighbor count
  function automatic logic [RCP_W-1:0] recip_of(logic [3:0] n);
    logic [RCP_W-1:0] m;
    unique case (n)
      4'd2:    m = RCP_W'(32768);
      4'd3:    m = RCP_W'(21846);
      4'd4:    m = RCP_W'(16384);
      4'd6:    m = RCP_W'(10923);
      4'd9:    m = RCP_W'(7282);
      default: m = RCP_W'(65536);
    endcase
    return m;
  endfunction

endpackage

// ===== design/bb3_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3_ctrl
// sequencer: take item, read line buffers, advance window, sum, divide, output
// ----------------------------------------------------------------------------
module bb3_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  bb3_pkg::bb3_stat_t  stat,
  output bb3_pkg::bb3_cmd_t   cmd
);
  import bb3_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state, state_next;
  logic             op_q, op_q_next;
  logic             second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_q   <= OP_PIXEL;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      op_q   <= op_q_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_q_next   = op_q;
    second_next = second;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_PIXEL && stat.pix_ok) begin
            cmd.take_pix = 1'b1;
            op_q_next    = OP_PIXEL;
            second_next  = 1'b0;
            state_next   = S_READ;
          end else if (in_op == OP_DRAIN && stat.drain_ok) begin
            cmd.take_drain = 1'b1;
            op_q_next      = OP_DRAIN;
            second_next    = 1'b0;
            state_next     = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.advance = 1'b1;
        if (stat.hit) begin
          state_next = S_SUM;
        end else if (op_q == OP_DRAIN && !second) begin
          second_next = 1'b1;
          state_next  = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_end  = (op_q == OP_DRAIN) && stat.last_pend;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/bb3_dp.sv =====
// ----------------------------------------------------------------------------
// bb3_dp
// line buffers, 3x3 window, raster counters, border sums and rounding divide
// ----------------------------------------------------------------------------
module bb3_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  bb3_pkg::bb3_cmd_t            cmd,
  output bb3_pkg::bb3_stat_t           stat,
  input  logic [bb3_pkg::PIX_W-1:0]    in_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]    cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bb3_pkg::PIX_W-1:0]    out_data,
  output logic                         out_last
);
  import bb3_pkg::*;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [ADDR_W-1:0] col;
  logic [ROW_W-1:0]  row;
  logic [PEND_W-1:0] pend;
  logic [PIX_W-1:0]  px, top_q, mid_q;
  logic [PIX_W-1:0]  win [9];
  logic [2:0]        rmask, cmask;
  logic [DVD_W-1:0]  dvd [3];
  logic [DVD_W-1:0]  quo [3];
  logic [RCP_W-1:0]  rcp;
  logic [PIX_W-1:0]  upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_line [MAX_WIDTH];

  logic [EW_W-1:0]   w_eff, col_inc;
  logic [FH_W-1:0]   h_eff;
  logic              hit, restart;
  logic [ROW_W-1:0]  cr;
  logic [ADDR_W-1:0] cc;
  logic [2:0]        rm, cm;
  logic [SUM_W-1:0]  sum [3];
  logic [3:0]        n;
  logic [DVD_W-1:0]  dvd_init [3];
  logic [PROD_W-1:0] prod [3];

  assign w_eff   = clamp_width(frame_width);
  assign h_eff   = clamp_height(frame_height);
  assign col_inc = {1'b0, col} + 1'b1;
  assign restart = cfg_we || (cmd.out_load && cmd.out_end);

  always_comb begin
    hit = 1'b0;
    cr  = '0;
    cc  = '0;
    if (col != '0 && row != '0) begin
      hit = 1'b1;
      cr  = row - 1'b1;
      cc  = col - 1'b1;
    end else if (col == '0 && row >= ROW_W'(2)) begin
      hit = 1'b1;
      cr  = row - ROW_W'(2);
      cc  = ADDR_W'(w_eff - 1'b1);
    end
    rm[0] = cr != '0;
    rm[1] = cr < h_eff;
    rm[2] = ({1'b0, cr} + 1'b1) < {1'b0, h_eff};
    cm[0] = cc != '0;
    cm[1] = 1'b1;
    cm[2] = ({1'b0, cc} + 1'b1) < w_eff;
  end

  assign stat.pix_ok    = row < h_eff;
  assign stat.drain_ok  = !(row < h_eff) && pend != '0;
  assign stat.hit       = hit;
  assign stat.last_pend = pend == PEND_W'(1);
  assign stat.out_free  = !out_valid || out_ready;

  // config and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      row  <= '0;
      pend <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      if (cmd.take_pix) pend <= pend + 1'b1;
      else if (cmd.out_load) pend <= pend - 1'b1;
      if (cmd.advance) begin
        if (col_inc >= w_eff) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col_inc[ADDR_W-1:0];
        end
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= top_q;
        win[5] <= mid_q;
        win[8] <= px;
      end
    end
  end

  // line buffers
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) top_q <= upper_line[col];
    if (cmd.advance) upper_line[col] <= mid_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) mid_q <= middle_line[col];
    if (cmd.advance) middle_line[col] <= px;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pix) px <= {in_data[7:0], in_data[15:8], in_data[23:16]};
    else if (cmd.take_drain) px <= '0;
    if (cmd.advance) begin
      rmask <= rm;
      cmask <= cm;
    end
  end

  // border-aware sums, channel 0 blue, 1 green, 2 red
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int ri = 0; ri < 3; ri++) begin
        for (int ci = 0; ci < 3; ci++) begin
          if (rmask[ri] && cmask[ci]) begin
            sum[ch] = sum[ch] + SUM_W'(win[ri*3+ci][PIX_W-1-ch*CH_W -: CH_W]);
          end
        end
      end
    end
    n = 4'(count3(rmask)) * 4'(count3(cmask));
    if (n == '0) n = 4'd1;
    for (int ch = 0; ch < 3; ch++) begin
      dvd_init[ch] = {sum[ch], 1'b0} + DVD_W'(n);
    end
  end

  // divide by 2*n as a multiply by its rounded-up reciprocal
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(dvd[ch]) * PROD_W'(rcp);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      rcp <= recip_of(n);
      for (int ch = 0; ch < 3; ch++) begin
        dvd[ch] <= dvd_init[ch];
      end
    end else if (cmd.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        quo[ch] <= prod[ch][RCP_SH +: DVD_W];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {quo[2][CH_W-1:0], quo[1][CH_W-1:0], quo[0][CH_W-1:0]};
      out_last <= cmd.out_end;
    end
  end

endmodule

// ===== design/box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// streaming 3x3 box blur over 24-bit rgb pixels in raster order
// ----------------------------------------------------------------------------
// An accepted item that yields an output pixel passes through accept, line
// buffer read, window advance, sum, reciprocal multiply and output load;
// one that yields none stops after the window advance, and a drain step that
// does not hit on its first advance reads and advances a second time. The
// output load waits while the previous pixel still sits unread on the output
// side. Outputs trail the inputs by frame_width+1 raster positions; after the
// last pixel of a frame, send drain items (tuser high) until the output with tlast.
// The next item is taken while a finished pixel waits on the output side.
// A configuration write restarts the frame.
module box_blur_3x3_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import bb3_pkg::*;

  bb3_cmd_t  cmd;
  bb3_stat_t stat;

  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bb3_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== design/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker
// port-level checks for the box blur, attached by bind
// ----------------------------------------------------------------------------
module bb3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_rst_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("input not ready after reset");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
